>>> rtl/core/iss_pkg.sv
`default_nettype none

package iss_pkg;

   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;

   typedef enum logic [0:0] {
      CSR_ASCENDING = 1'b0
   } csr_index_type;

   typedef struct packed {
      logic insert;
      logic shift_down;
      logic shift_up;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/core/iss_cell.sv
`default_nettype none

module iss_cell #(
   parameter int unsigned VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire iss_pkg::cell_ctrl_type ctrl,
   input  wire logic [VALUE_BITS-1:0] ins_value,
   input  wire logic [VALUE_BITS-1:0] low_value,
   input  wire logic                  low_valid,
   input  wire logic                  low_take,
   input  wire logic [VALUE_BITS-1:0] high_value,
   input  wire logic                  high_valid,
   output logic [VALUE_BITS-1:0]      value,
   output logic                       valid,
   output logic                       take
);

   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;
   logic                  valid_ff;
   logic                  valid_in;

   // insertion point: first empty slot or first slot holding a larger value
   assign take  = !valid_ff || ($signed(value_ff) > $signed(ins_value));
   assign value = value_ff;
   assign valid = valid_ff;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.insert) begin
         if (low_take) begin
            value_in = low_value;
            valid_in = low_valid;
         end else if (take) begin
            value_in = ins_value;
            valid_in = 1'b1;
         end
      end else if (ctrl.shift_down) begin
         value_in = high_value;
         valid_in = high_valid;
      end else if (ctrl.shift_up) begin
         value_in = low_value;
         valid_in = low_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/integer_sorter_up_down.sv
`default_nettype none

// Channel   Direction  Ports                                        Transaction
// req       in         req_valid/req_stall, value, is_last          one value of a set
// rsp       out        rsp_valid/rsp_stall, sorted_value, last_out,  one sorted value
//                      overflowed
// csr       in/out     APB: psel, penable, pwrite, paddr, pwdata     bit 0 of reg 0: ascending
//
// Loading takes one value per cycle; each value is inserted into a chain of DEPTH cells
// kept in ascending order. After the is_last transaction req_stall stays high while the
// chain drains one cell per cycle while rsp_stall allows, from cell 0 for ascending
// order and from cell DEPTH-1 for descending order (the chain shifts toward its top end).
// The output register lets the next set start loading while the final result waits.
// Reset (synchronous) empties the chain and sets ascending order.
module integer_sorter_up_down #(
   parameter int unsigned DEPTH      = 64,
   parameter int unsigned VALUE_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [VALUE_BITS-1:0]              req_value,
   input  wire logic                               req_is_last,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [VALUE_BITS-1:0]                   rsp_sorted_value,
   output logic                                    rsp_last_out,
   output logic                                    rsp_overflowed,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [iss_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [iss_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [iss_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                    csr_pready
);

   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   rem_ff, rem_in;
   logic                  drop_ff, drop_in;
   logic                  asc_ff, asc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   iss_pkg::cell_ctrl_type ctrl;
   logic [VALUE_BITS-1:0]  cell_value [DEPTH];
   logic                   cell_valid [DEPTH];
   logic                   cell_take  [DEPTH];

   logic                   accept, full, advance, csr_write, csr_hit;
   logic [VALUE_BITS-1:0]  end_value;
   logic                   end_valid;

   assign req_stall = (state_ff == ST_DRAIN);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign advance   = (state_ff == ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);
   assign end_value = asc_ff ? cell_value[0] : cell_value[DEPTH-1];
   assign end_valid = asc_ff ? cell_valid[0] : cell_valid[DEPTH-1];

   assign ctrl.insert     = accept && !full;
   assign ctrl.shift_down = advance && asc_ff;
   assign ctrl.shift_up   = advance && !asc_ff;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic [VALUE_BITS-1:0] lo_value, hi_value;
         logic                  lo_valid, lo_take, hi_valid;
         if (i == 0) begin : g_lo_edge
            assign lo_value = '0;
            assign lo_valid = 1'b0;
            assign lo_take  = 1'b0;
         end else begin : g_lo
            assign lo_value = cell_value[i-1];
            assign lo_valid = cell_valid[i-1];
            assign lo_take  = cell_take[i-1];
         end
         if (i == DEPTH - 1) begin : g_hi_edge
            assign hi_value = '0;
            assign hi_valid = 1'b0;
         end else begin : g_hi
            assign hi_value = cell_value[i+1];
            assign hi_valid = cell_valid[i+1];
         end
         iss_cell #(
            .VALUE_BITS (VALUE_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .ins_value  (req_value),
            .low_value  (lo_value),
            .low_valid  (lo_valid),
            .low_take   (lo_take),
            .high_value (hi_value),
            .high_valid (hi_valid),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .take       (cell_take[i])
         );
      end
   endgenerate

   // configuration
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == iss_pkg::CSR_ASCENDING);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_prdata = csr_hit ? {{(iss_pkg::CSR_DATA_BITS-1){1'b0}}, asc_ff} : '0;
   assign asc_in     = csr_write ? csr_pwdata[0] : asc_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (!full) begin
                  count_in = count_ff + CNT_BITS'(1);
               end
               drop_in = drop_ff || full;
               if (req_is_last) begin
                  rem_in   = full ? count_ff : count_ff + CNT_BITS'(1);
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (advance) begin
               rsp_valid_in = end_valid;
               rsp_value_in = end_value;
               rsp_last_in  = (rem_ff == CNT_BITS'(1));
               rsp_ovf_in   = drop_ff;
               if (end_valid) begin
                  rem_in = rem_ff - CNT_BITS'(1);
                  if (rem_ff == CNT_BITS'(1)) begin
                     state_in = ST_LOAD;
                     count_in = '0;
                     drop_in  = 1'b0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rem_ff       <= rem_in;
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         asc_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         asc_ff       <= asc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

endmodule

`default_nettype wire

>>> tb/integer_sorter_up_down_test.sv
`timescale 1ns / 1ps

module integer_sorter_up_down_test;

   localparam int unsigned DEPTH        = 64;
   localparam int unsigned VALUE_BITS   = 32;
   localparam int unsigned ADDR_BITS    = iss_pkg::CSR_ADDR_BITS;
   localparam int unsigned DATA_BITS    = iss_pkg::CSR_DATA_BITS;
   localparam int unsigned UNMAPPED_REG = 1;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          LONG_HOLD    = 300;
   localparam int          SETTLE       = 2 * DEPTH + 10;
   localparam int          PHASE_ITEMS  = 45;

   typedef struct {
      logic signed [VALUE_BITS-1:0] value;
      logic                         is_last;
   } sort_input_type;

   typedef struct {
      logic signed [VALUE_BITS-1:0] value;
      logic                         last_out;
      logic                         overflowed;
   } sorted_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   wire logic                    req_stall;
   logic [VALUE_BITS-1:0]        req_value = '0;
   logic                         req_is_last = 1'b0;
   wire logic                    rsp_valid;
   logic                         rsp_stall = 1'b0;
   wire logic [VALUE_BITS-1:0]   rsp_sorted_value;
   wire logic                    rsp_last_out;
   wire logic                    rsp_overflowed;
   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [ADDR_BITS-1:0]         csr_paddr = '0;
   logic [DATA_BITS-1:0]         csr_pwdata = '0;
   wire logic [DATA_BITS-1:0]    csr_prdata;
   wire logic                    csr_pready;

   sort_input_type               pending_inputs[$];
   sorted_result_type            expected_sorted[$];

   logic signed [VALUE_BITS-1:0] held_vals [DEPTH];
   int                           held_num = 0;
   bit                           held_drop = 1'b0;
   bit                           model_ascending = 1'b1;

   int                           cycle_count = 0;
   int                           error_count = 0;
   int                           req_taken = 0;
   int                           req_seen = 0;
   int                           send_idle_pct = 0;
   int                           rsp_idle_pct = 0;
   bit                           hold_arm = 1'b0;
   bit                           hold_done = 1'b0;
   int                           hold_left = 0;

   integer_sorter_up_down #(
      .DEPTH(DEPTH),
      .VALUE_BITS(VALUE_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .req_is_last(req_is_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_last_out(rsp_last_out),
      .rsp_overflowed(rsp_overflowed),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic predict_sort(input sort_input_type item);
      logic signed [VALUE_BITS-1:0] ordered [DEPTH];
      logic signed [VALUE_BITS-1:0] cur;
      int j;
      sorted_result_type res;
      if (held_num < DEPTH) begin
         held_vals[held_num] = item.value;
         held_num++;
      end else begin
         held_drop = 1'b1;
      end
      if (item.is_last) begin
         ordered = held_vals;
         for (int i = 1; i < held_num; i++) begin
            cur = ordered[i];
            j = i;
            while (j > 0 && (model_ascending ? (cur < ordered[j-1]) : (cur > ordered[j-1]))) begin
               ordered[j] = ordered[j-1];
               j--;
            end
            ordered[j] = cur;
         end
         for (int k = 0; k < held_num; k++) begin
            res.value      = ordered[k];
            res.last_out   = (k == held_num - 1);
            res.overflowed = held_drop;
            expected_sorted.push_back(res);
         end
         held_num  = 0;
         held_drop = 1'b0;
      end
   endtask

   function automatic logic [VALUE_BITS-1:0] random_value();
      case ($urandom_range(0, 3))
         0: random_value = VALUE_BITS'($urandom_range(0, 7)) - VALUE_BITS'(4);
         1: random_value = $urandom_range(0, 1) ? {1'b0, {(VALUE_BITS-1){1'b1}}}
                                                : {1'b1, {(VALUE_BITS-1){1'b0}}};
         default: random_value = $urandom;
      endcase
   endfunction

   task automatic push_input(input logic [VALUE_BITS-1:0] value, input logic is_last);
      sort_input_type item;
      item.value   = value;
      item.is_last = is_last;
      pending_inputs.push_back(item);
   endtask

   task automatic queue_set(input int size);
      for (int k = 0; k < size; k++) begin
         push_input(random_value(), k == size - 1);
      end
   endtask

   task automatic queue_random_sets(input int budget);
      int added;
      int size;
      added = 0;
      while (added < budget) begin
         if ($urandom_range(0, 15) == 0) begin
            size = $urandom_range(DEPTH - 1, DEPTH + 3);
         end else begin
            size = $urandom_range(1, 10);
         end
         queue_set(size);
         added += size;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_inputs.size() != 0 || req_valid || expected_sorted.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   // write, then read back the ascending register
   task automatic csr_write(input int unsigned index, input logic [DATA_BITS-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_BITS'(index * 4);
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      if (index == int'(iss_pkg::CSR_ASCENDING)) begin
         model_ascending = data[0];
      end
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_BITS'(int'(iss_pkg::CSR_ASCENDING) * 4);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      if (csr_prdata[0] !== model_ascending) begin
         report_mismatch($sformatf("ascending reads %b, expected %b",
                                   csr_prdata[0], model_ascending));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   always @(negedge clock) begin : drive_req
      sort_input_type item;
      bit busy;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         busy = req_valid && (req_taken == req_seen);
         req_seen = req_taken;
         if (!busy) begin
            if (pending_inputs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               item = pending_inputs.pop_front();
               req_value   <= item.value;
               req_is_last <= item.is_last;
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin : drive_rsp_stall
      bit stall_next;
      if (hold_arm && !hold_done) begin
         hold_left = LONG_HOLD;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         stall_next = 1'b1;
      end else begin
         stall_next = ($urandom_range(0, 99) < rsp_idle_pct);
      end
      rsp_stall <= stall_next;
   end

   always @(posedge clock) begin : watch_req
      sort_input_type item;
      if (!reset && req_valid && !req_stall) begin
         item.value   = req_value;
         item.is_last = req_is_last;
         predict_sort(item);
         req_taken++;
      end
   end

   always @(posedge clock) begin : check_rsp
      sorted_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sorted.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", $signed(rsp_sorted_value)));
         end else begin
            want = expected_sorted.pop_front();
            if (rsp_sorted_value !== want.value) begin
               report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                         $signed(rsp_sorted_value), want.value));
            end
            if (rsp_last_out !== want.last_out) begin
               report_mismatch($sformatf("last_out %b, expected %b",
                                         rsp_last_out, want.last_out));
            end
            if (rsp_overflowed !== want.overflowed) begin
               report_mismatch($sformatf("overflowed %b, expected %b",
                                         rsp_overflowed, want.overflowed));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset order is ascending
      send_idle_pct = 10;
      rsp_idle_pct  = 80;
      push_input(32'h8000_0000, 1'b1);
      push_input(32'h7FFF_FFFF, 1'b1);
      push_input(32'h0000_0000, 1'b0);
      push_input(32'hFFFF_FFFF, 1'b0);
      push_input(32'h7FFF_FFFF, 1'b0);
      push_input(32'h8000_0000, 1'b0);
      push_input(32'h0000_0001, 1'b0);
      push_input(32'h5555_5555, 1'b0);
      push_input(32'hAAAA_AAAA, 1'b0);
      push_input(32'h0000_0000, 1'b1);
      wait_drained();

      csr_write(iss_pkg::CSR_ASCENDING, 32'hFFFF_FFFE);
      push_input(32'h0000_0000, 1'b0);
      push_input(32'hAAAA_AAAA, 1'b0);
      push_input(32'h5555_5555, 1'b0);
      push_input(32'h0000_0001, 1'b0);
      push_input(32'h8000_0000, 1'b0);
      push_input(32'h7FFF_FFFF, 1'b0);
      push_input(32'hFFFF_FFFF, 1'b0);
      push_input(32'h0000_0000, 1'b1);
      push_input(32'hFFFF_FFFF, 1'b1);
      wait_drained();

      csr_write(UNMAPPED_REG, 32'h0000_0001);

      send_idle_pct = 10;
      rsp_idle_pct  = 80;
      csr_write(iss_pkg::CSR_ASCENDING, $urandom | 32'h1);
      queue_random_sets(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 80;
      rsp_idle_pct  = 10;
      csr_write(iss_pkg::CSR_ASCENDING, $urandom & ~32'h1);
      queue_random_sets(PHASE_ITEMS);
      wait_drained();

      // full set with the closing value dropped, under a long receiver hold
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      csr_write(iss_pkg::CSR_ASCENDING, $urandom | 32'h1);
      queue_set(DEPTH + 2);
      queue_random_sets(PHASE_ITEMS);
      hold_arm = 1'b1;
      wait_drained();

      csr_write(iss_pkg::CSR_ASCENDING, $urandom & ~32'h1);
      queue_random_sets(PHASE_ITEMS);
      wait_drained();

      if (error_count == 0 && expected_sorted.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
